@@ rtl/rtucrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtucrc_pkg
// Shared types and constants for the RTU frame CRC checker.
// ----------------------------------------------------------------------------
package rtucrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One check result, as produced on the last byte of a frame.
    typedef struct packed {
        logic [15:0] computed_crc;
        logic        too_short;
        logic        crc_ok;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/rtu_frame_crc_checker_top.sv @@
// ----------------------------------------------------------------------------
// rtu_frame_crc_checker_top
// Byte-stream checker for serial-bus RTU frames with a reflected CRC-16.
// ----------------------------------------------------------------------------
// The block takes one frame byte per transaction on the slave stream, with
// s_tlast marking the final byte of a frame, and returns exactly one result
// transaction per frame on the master stream. The CRC (polynomial 0xA001,
// start value 0xFFFF) covers every byte except the final two, and the frame
// passes when those two bytes equal the CRC in either byte order. A frame of
// a single byte is reported as too short and fails, with the CRC at 0xFFFF.
// All frame state clears after the last byte, so frames may follow each other
// without a gap. The block sustains one byte per clock cycle while the result
// buffer has room: each byte is held in an input register, and the eight-bit
// CRC update and the trailer compare run combinationally between that register
// and a two-entry result buffer, from which results go to the master side.
// The result buffer lets input continue while a result waits for the sink.
// ----------------------------------------------------------------------------
module rtu_frame_crc_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream. s_tdata: [7:0] data_byte. s_tlast carries last_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // Result stream. m_tdata: [0] crc_ok, [1] too_short, [17:2] computed_crc,
    // [23:18] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    // Input register stage holding one accepted byte.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic                advance;
    logic                can_push;
    logic                result_push;
    rtucrc_pkg::result_t result;
    rtucrc_pkg::result_t out_data;

    // The held byte moves on whenever the result buffer has room; a byte that
    // is not last needs no room but waits too, which keeps the control simple
    // and still allows one byte every cycle while the sink keeps up.
    assign advance  = in_valid_reg && can_push;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Window, running CRC and end-of-frame comparison.
    rtucrc_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .data_byte   (in_byte_reg),
        .last_byte   (in_last_reg),
        .result_push (result_push),
        .result      (result)
    );

    // Result buffer toward the master stream.
    rtucrc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (result_push),
        .push_data (result),
        .can_push  (can_push),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = {6'b000000, out_data};

endmodule

@@ rtl/rtucrc_frame.sv @@
// ----------------------------------------------------------------------------
// rtucrc_frame
// Per-frame state: two-byte window, running CRC and the end-of-frame check.
// ----------------------------------------------------------------------------
module rtucrc_frame (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                result_push,
    output rtucrc_pkg::result_t result
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  older_reg, older_next;
    logic [7:0]  newer_reg, newer_next;
    logic [1:0]  fill_reg, fill_next;

    logic [15:0] crc_folded;
    logic [1:0]  fill_upd;
    logic [15:0] hi_first;
    logic [15:0] lo_first;
    logic        short_frame;

    // Reflected CRC-16 update for one byte, bit by bit.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ rtucrc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    always_comb begin
        crc_folded  = (fill_reg >= 2'd2) ? crc_fold(crc_reg, older_reg) : crc_reg;
        fill_upd    = (fill_reg >= 2'd2) ? 2'd2 : fill_reg + 2'd1;
        short_frame = (fill_upd < 2'd2);
        hi_first    = {newer_reg, data_byte};
        lo_first    = {data_byte, newer_reg};

        result.crc_ok       = !short_frame && (crc_folded == hi_first || crc_folded == lo_first);
        result.too_short    = short_frame;
        result.computed_crc = crc_folded;
        result_push         = advance && last_byte;

        crc_next   = crc_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        fill_next  = fill_reg;
        if (advance) begin
            if (last_byte) begin
                crc_next   = rtucrc_pkg::CRC_INIT;
                older_next = 8'h00;
                newer_next = 8'h00;
                fill_next  = 2'd0;
            end else begin
                crc_next   = crc_folded;
                older_next = newer_reg;
                newer_next = data_byte;
                fill_next  = fill_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= rtucrc_pkg::CRC_INIT;
            older_reg <= 8'h00;
            newer_reg <= 8'h00;
            fill_reg  <= 2'd0;
        end else begin
            crc_reg   <= crc_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

@@ rtl/rtucrc_out_buf.sv @@
// ----------------------------------------------------------------------------
// rtucrc_out_buf
// Two-entry result buffer that decouples the check logic from the sink.
// ----------------------------------------------------------------------------
module rtucrc_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rtucrc_pkg::result_t push_data,
    output logic                can_push,
    output logic                m_valid,
    input  logic                m_ready,
    output rtucrc_pkg::result_t m_data
);

    logic [1:0]          count_reg, count_next;
    rtucrc_pkg::result_t ent0_reg, ent0_next;
    rtucrc_pkg::result_t ent1_reg, ent1_next;
    logic                pop;
    logic [1:0]          count_after_pop;

    assign can_push = (count_reg != 2'd2);
    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = ent0_reg;
    assign pop      = m_valid && m_ready;

    always_comb begin
        ent0_next       = ent0_reg;
        ent1_next       = ent1_reg;
        count_after_pop = count_reg;
        if (pop) begin
            ent0_next       = ent1_reg;
            count_after_pop = count_reg - 2'd1;
        end
        count_next = count_after_pop;
        if (push) begin
            if (count_after_pop == 2'd0) begin
                ent0_next = push_data;
            end else begin
                ent1_next = push_data;
            end
            count_next = count_after_pop + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

@@ test/tb_rtu_frame_crc_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtu_frame_crc_checker_top
// Self-checking bench for the RTU frame CRC checker.
// ----------------------------------------------------------------------------
// A short directed set of frames comes first. It covers one-byte frames,
// two-byte frames, a CRC trailer in each byte order, a corrupted trailer and
// the byte extremes. Random frames follow. Most of them carry a correct
// trailer, and the rest are corrupted trailers, lone bytes and noise. Every
// accepted byte goes through a local model of the CRC window. Each result
// transaction is compared field by field with the oldest predicted result.
// Both sides idle in random bursts. At one point the result side holds off
// for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_rtu_frame_crc_checker_top;

    localparam int TOTAL_BYTES_TARGET = 1050;
    localparam int QUIET_BYTES        = 150;   // final bytes sent with no idling
    localparam int HOLD_AT            = 300;   // accepted bytes before the long hold
    localparam int HOLD_LEN           = 400;
    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int DRAIN_CYCLES       = 8;

    // Ways the two trailing bytes of a generated frame can be formed.
    typedef enum {
        TRAILER_LO_FIRST,
        TRAILER_HI_FIRST,
        TRAILER_CORRUPT
    } trailer_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Bytes waiting to be offered, and the results the model says must come.
    frame_byte_t         pending_bytes[$];
    rtucrc_pkg::result_t expected_checks[$];
    logic [7:0]          frame_buf[$];

    // Local copy of the checker state, advanced on every accepted byte.
    logic [15:0] crc_run   = rtucrc_pkg::CRC_INIT;
    logic [7:0]  win_older = 8'h00;
    logic [7:0]  win_newer = 8'h00;
    logic [1:0]  win_fill  = 2'd0;

    int   total_bytes    = 0;
    int   accepted_bytes = 0;
    int   tx_gap         = 0;
    int   rx_gap         = 0;
    int   stall_cycles   = 0;
    int   hold_cycles    = 0;
    logic hold_active    = 1'b0;
    logic hold_done      = 1'b0;
    int   mismatches     = 0;
    int   frames_checked = 0;
    int   frames_ok      = 0;
    int   frames_short   = 0;
    logic quiet_tail;

    assign quiet_tail = (accepted_bytes + QUIET_BYTES >= total_bytes);

    rtu_frame_crc_checker_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // One byte of the reflected CRC-16, shifted out least significant bit first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ rtucrc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advances the local window and CRC by one byte. On the last byte it
    // queues the expected result and clears for the next frame.
    task automatic fold_frame_byte(input logic [7:0] b, input logic last);
        rtucrc_pkg::result_t r;
        logic [15:0]         hi_first;
        logic [15:0]         lo_first;
        if (win_fill >= 2'd2) begin
            crc_run = crc16_update(crc_run, win_older);
        end
        win_older = win_newer;
        win_newer = b;
        if (win_fill < 2'd2) begin
            win_fill = win_fill + 2'd1;
        end
        if (last) begin
            hi_first       = {win_older, win_newer};
            lo_first       = {win_newer, win_older};
            r.too_short    = (win_fill < 2'd2);
            r.crc_ok       = !r.too_short && (crc_run == hi_first || crc_run == lo_first);
            r.computed_crc = crc_run;
            expected_checks.push_back(r);
            crc_run   = rtucrc_pkg::CRC_INIT;
            win_older = 8'h00;
            win_newer = 8'h00;
            win_fill  = 2'd0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back('{data: b, last: last});
    endtask

    // Sends the payload collected in frame_buf, then two trailer bytes.
    task automatic emit_frame(input trailer_kind_t kind);
        logic [15:0] crc;
        logic [15:0] trailer;    // first byte on the wire in the upper half
        crc = rtucrc_pkg::CRC_INIT;
        foreach (frame_buf[i]) begin
            crc = crc16_update(crc, frame_buf[i]);
            push_byte(frame_buf[i], 1'b0);
        end
        case (kind)
            TRAILER_LO_FIRST: begin
                trailer = {crc[7:0], crc[15:8]};
            end
            TRAILER_HI_FIRST: begin
                trailer = crc;
            end
            default: begin
                trailer = {crc[7:0], crc[15:8]} ^ (16'h0001 << $urandom_range(0, 15));
            end
        endcase
        push_byte(trailer[15:8], 1'b0);
        push_byte(trailer[7:0], 1'b1);
        frame_buf.delete();
    endtask

    // Stimulus is built in full at time zero. The driver then drains the
    // queue while reset is released.
    initial begin
        int pick;
        int len;

        // Frames of one byte are too short, whatever the byte holds.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // A two-byte frame checks against the untouched start value.
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // A typical read request with the CRC sent low byte first.
        frame_buf = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01};
        emit_frame(TRAILER_LO_FIRST);
        // The swapped byte order is accepted as well.
        frame_buf = '{8'hFF, 8'h00, 8'h80};
        emit_frame(TRAILER_HI_FIRST);
        frame_buf = '{8'h7F, 8'h55};
        emit_frame(TRAILER_CORRUPT);

        // Random part: mostly well-formed frames with random content.
        while (pending_bytes.size() < TOTAL_BYTES_TARGET) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (pick < 85) begin
                repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
                emit_frame(pick < 40 ? TRAILER_LO_FIRST :
                           pick < 70 ? TRAILER_HI_FIRST : TRAILER_CORRUPT);
            end else if (pick < 92) begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                for (int i = 0; i <= len; i++) begin
                    push_byte(8'($urandom_range(0, 255)), i == len);
                end
            end
        end
        total_bytes = pending_bytes.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || expected_checks.size() != 0) begin
            @(posedge aclk);
        end
        // Any stray result that shows up during this pause is flagged by the monitor.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d frames over %0d bytes: %0d passed the CRC, %0d were too short.",
                 frames_checked, total_bytes, frames_ok, frames_short);
        $display("The result side was held off once for %0d cycles with input still offered.",
                 HOLD_LEN);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Input driver. A byte stays on the bus until it is taken. Between bytes
    // the driver may insert an idle burst, except in the final stretch.
    always @(posedge aclk) begin : byte_driver
        frame_byte_t sent;
        logic        offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                sent = pending_bytes.pop_front();
                fold_frame_byte(sent.data, sent.last);
                accepted_bytes <= accepted_bytes + 1;
            end
            if (s_tvalid && !s_tready) begin
                offer = 1'b1;
            end else if (pending_bytes.size() == 0) begin
                offer = 1'b0;
            end else if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                offer  = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
                tx_gap = $urandom_range(0, 18);
                offer  = 1'b0;
            end else begin
                offer = 1'b1;
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= pending_bytes[0].data;
                s_tlast <= pending_bytes[0].last;
            end
        end
    end

    // Long hold-off on the result side. It starts once a few hundred bytes
    // have gone through.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_active) begin
            if (hold_cycles == HOLD_LEN - 1) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            hold_cycles <= hold_cycles + 1;
        end else if (!hold_done && accepted_bytes >= HOLD_AT) begin
            hold_active <= 1'b1;
            hold_cycles <= 0;
        end
    end

    // Result-side ready, which drops in random bursts outside the hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else if (hold_active) begin
            m_tready <= 1'b0;
        end else if (quiet_tail) begin
            m_tready <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor. It compares every accepted transaction with the oldest
    // prediction.
    always @(posedge aclk) begin : result_monitor
        rtucrc_pkg::result_t got;
        rtucrc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = rtucrc_pkg::result_t'(m_tdata[rtucrc_pkg::RESULT_W-1:0]);
            if (expected_checks.size() == 0) begin
                $error("result with no frame outstanding: m_tdata %h", m_tdata);
                mismatches = mismatches + 1;
            end else begin
                want = expected_checks.pop_front();
                frames_checked = frames_checked + 1;
                if (want.crc_ok) frames_ok = frames_ok + 1;
                if (want.too_short) frames_short = frames_short + 1;
                if (got.crc_ok !== want.crc_ok) begin
                    $error("crc_ok: expected %0d, got %0d", want.crc_ok, got.crc_ok);
                    mismatches = mismatches + 1;
                end
                if (got.too_short !== want.too_short) begin
                    $error("too_short: expected %0d, got %0d", want.too_short, got.too_short);
                    mismatches = mismatches + 1;
                end
                if (got.computed_crc !== want.computed_crc) begin
                    $error("computed_crc: expected %h, got %h",
                           want.computed_crc, got.computed_crc);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[23:rtucrc_pkg::RESULT_W] !== '0) begin
                    $error("m_tdata padding: expected 0, got %h",
                           m_tdata[23:rtucrc_pkg::RESULT_W]);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Watchdog. It counts cycles in which neither side completes a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles.", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
